// File: hw/rtl/pwl_pkg.sv
`default_nettype none
package pwl_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_RESULT   = 3'd0,
    ST_NOLIMIT  = 3'd1,
    ST_SHORT    = 3'd2,
    ST_APPENDED = 3'd3,
    ST_REJECT   = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,
    S_APPEND,
    S_RD_FIRST,
    S_CHK_ENDS,
    S_SEARCH,
    S_SEARCH_WAIT,
    S_RD_PREV,
    S_RD_CURR,
    S_MUL,
    S_PROD,
    S_DIV_GO,
    S_DIV,
    S_DONE
  } state_t;

  localparam int unsigned DivSteps = 64;

endpackage
`default_nettype wire

// File: hw/rtl/pwl_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle over a 64-bit dividend.
// Quotient saturates to 32 bits.
module pwl_divider
  import pwl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [31:0]      quotient
);

  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  count;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 7'(DivSteps);
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = (quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo[31:0];

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) busy && !start |=> count == $past(count) - 7'd1)
    else $error("divider count skipped");

endmodule
`default_nettype wire

// File: hw/rtl/pwl_table_mem.sv
`default_nettype none
// Point table: range and energy side by side, one write and one registered read per cycle.
module pwl_table_mem #(
  parameter int unsigned AW = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [63:0]   wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic [63:0]        rd_data
);

  logic [63:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/piecewise_linear_table_interp.sv
`default_nettype none
// Piecewise-linear energy-from-range lookup over a fill-in point table.
// One input channel (in_valid/in_stall with op, key_range, point_energy)
// and one result channel (out_valid/out_stall with energy, status). Every
// input transfer produces exactly one result transfer.
// Items are handled one at a time; the next input is taken only after the
// result of the last one has been transferred. A clear or an unused code
// goes straight to the result, an append first reads the last point of the
// table and then writes, and a query on fewer than two points ends once
// the last entry has been read. Any other query makes P search probes, at
// most ceil(log2(count + 1)), so 9 on a full table and 1 when the key lies
// outside the table. Each probe passes through SEARCH and SEARCH_WAIT on
// the registered-read table memory, and the restoring divider produces one
// bit of the 64-bit quotient per cycle. The divider sets the rate.
// Reset empties the table by zeroing the point count; the memory itself is
// not cleared, and entries that were never written never affect a result.
// The result sits in an output register. While the receiver stalls it holds,
// and the block stalls the input until the result has been transferred.
module piecewise_linear_table_interp
  import pwl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] key_range,
  input  wire logic [31:0] point_energy,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      energy,
  output logic [2:0]       status
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  logic [CW-1:0] point_count;
  logic [31:0]   key_q;
  logic [31:0]   pe_q;
  logic [CW-1:0] lo, hi, mid;
  logic [31:0]   rp, ep, dr, dx, de;
  logic          rising;
  logic [63:0]   prod;

  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [63:0]   mem_rd;
  logic [31:0]   rd_range, rd_energy;

  logic          div_start, div_busy, div_done;
  logic [31:0]   div_q;

  assign rd_range  = mem_rd[63:32];
  assign rd_energy = mem_rd[31:0];
  assign mid       = lo + ((hi - lo) >> 1);

  pwl_table_mem #(.AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data ({key_q, pe_q}),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  pwl_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (dr),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall = (state != S_IDLE) || out_valid;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          case (op_t'(op))
            OP_APPEND: state_next = S_RD_LAST;
            OP_QUERY:  state_next = S_RD_FIRST;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_RD_LAST:     state_next = S_APPEND;
      S_APPEND:      state_next = S_DONE;
      S_RD_FIRST: begin
        if (point_count < CW'(2)) state_next = S_DONE;
        else state_next = S_CHK_ENDS;
      end
      S_CHK_ENDS:    state_next = S_SEARCH;
      S_SEARCH: begin
        if (lo >= hi) state_next = S_RD_PREV;
        else state_next = S_SEARCH_WAIT;
      end
      S_SEARCH_WAIT: state_next = S_SEARCH;
      S_RD_PREV:     state_next = S_RD_CURR;
      S_RD_CURR:     state_next = S_MUL;
      S_MUL:         state_next = S_PROD;
      S_PROD:        state_next = S_DIV_GO;
      S_DIV_GO:      state_next = S_DIV;
      S_DIV: begin
        if (div_done) state_next = S_DONE;
      end
      S_DONE:        state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  // Memory and divider control.
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = point_count[AW-1:0];
    mem_ra    = '0;
    div_start = 1'b0;
    case (state)
      S_IDLE:        mem_ra = '0;
      S_RD_LAST:     mem_ra = AW'(point_count - CW'(1));
      S_RD_FIRST:    mem_ra = AW'(point_count - CW'(1));
      S_SEARCH:      mem_ra = mid[AW-1:0];
      S_SEARCH_WAIT: mem_ra = mid[AW-1:0];
      S_RD_PREV:     mem_ra = AW'(lo - CW'(1));
      S_RD_CURR:     mem_ra = lo[AW-1:0];
      S_APPEND: begin
        mem_we = (point_count < CW'(TABLE_DEPTH)) &&
                 ((point_count == '0) || (key_q > rd_range));
      end
      S_DIV_GO:      div_start = 1'b1;
      default:       mem_ra = '0;
    endcase
  end

  // The query flow reads entry 0 in IDLE (address 0), the last entry in
  // RD_FIRST, and checks both ends in CHK_ENDS.
  logic [31:0] first_r;
  logic        outside;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_IDLE && in_valid && !in_stall) begin
        key_q   <= key_range;
        pe_q    <= point_energy;
        outside <= 1'b0;
        status  <= ST_REJECT;
        energy  <= '0;
        if (op_t'(op) == OP_CLEAR) begin
          point_count <= '0;
          status      <= ST_CLEARED;
        end
      end
      case (state)
        S_RD_FIRST: begin
          first_r <= rd_range;
          if (point_count < CW'(2)) status <= ST_SHORT;
        end
        S_CHK_ENDS: begin
          outside <= (key_q <= first_r) || (key_q >= rd_range);
          lo      <= '0;
          hi      <= point_count;
        end
        S_SEARCH: begin
          if (outside) begin
            lo <= '0;
            hi <= '0;
          end
        end
        S_SEARCH_WAIT: begin
          if (rd_range < key_q) lo <= mid + CW'(1);
          else hi <= mid;
        end
        S_APPEND: begin
          if (mem_we) begin
            point_count <= point_count + CW'(1);
            status      <= ST_APPENDED;
          end
        end
        S_RD_CURR: begin
          rp <= rd_range;
          ep <= rd_energy;
        end
        S_MUL: begin
          rising <= rd_energy >= ep;
          de     <= (rd_energy >= ep) ? rd_energy - ep : ep - rd_energy;
          dr     <= rd_range - rp;
          dx     <= key_q - rp;
        end
        S_DIV: begin
          if (div_done) begin
            if (outside || lo == '0 || lo >= point_count) begin
              status <= ST_NOLIMIT;
              energy <= '0;
            end else begin
              status <= ST_RESULT;
              if (rising) energy <= (div_q > ~ep) ? 32'hFFFF_FFFF : ep + div_q;
              else energy <= (div_q > ep) ? 32'd0 : ep - div_q;
            end
          end
        end
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Product registered in the cycle after the operands, before divide start.
  always_ff @(posedge clk) begin
    prod <= 64'(de) * 64'(dx);
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_IDLE)
    else $error("result pending while busy");
  assert property (@(posedge clk) disable iff (rst) point_count <= CW'(TABLE_DEPTH))
    else $error("point count overflow");
  assert property (@(posedge clk) disable iff (rst)
    mem_we |=> point_count == $past(point_count) + CW'(1))
    else $error("append without count update");
  assert property (@(posedge clk) disable iff (rst) div_busy |-> state == S_DIV)
    else $error("divider runs outside divide state");

endmodule
`default_nettype wire

// File: tb/sv/piecewise_linear_table_interp_test.sv
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interp_test;
  import pwl_pkg::*;

  localparam int Depth = 256;
  localparam int RandomItems = 750;

  // Software copy of the point table.
  // It works out the expected (energy, status) pair for every accepted item.
  class energy_scoreboard;
    logic [31:0] ranges[Depth];
    logic [31:0] energies[Depth];
    int unsigned count;
    logic [31:0] want_energy[$];
    logic [2:0] want_status[$];
    int errors;

    function void clear_table();
      count = 0;
    endfunction

    function void note_input(logic [1:0] o, logic [31:0] key, logic [31:0] pe);
      logic [31:0] e;
      logic [2:0] s;
      int unsigned lo, hi, mid;
      logic [31:0] rp, rc, ep, ec, de;
      logic [63:0] prod;
      e = '0;
      case (o)
        OP_CLEAR: begin
          count = 0;
          s = ST_CLEARED;
        end
        OP_APPEND: begin
          if (count >= Depth || (count > 0 && key <= ranges[count-1])) begin
            s = ST_REJECT;
          end else begin
            ranges[count] = key;
            energies[count] = pe;
            count++;
            s = ST_APPENDED;
          end
        end
        OP_QUERY: begin
          if (count < 2) begin
            s = ST_SHORT;
          end else if (key <= ranges[0] || key >= ranges[count-1]) begin
            s = ST_NOLIMIT;
          end else begin
            lo = 0;
            hi = count;
            while (lo < hi) begin
              mid = lo + ((hi - lo) >> 1);
              if (ranges[mid] < key) lo = mid + 1;
              else hi = mid;
            end
            rp = ranges[lo-1];
            rc = ranges[lo];
            ep = energies[lo-1];
            ec = energies[lo];
            de = (ec >= ep) ? ec - ep : ep - ec;
            // The step is truncated and never exceeds de, so no clamp is needed.
            prod = (64'(de) * 64'(key - rp)) / 64'(rc - rp);
            e = (ec >= ep) ? ep + prod[31:0] : ep - prod[31:0];
            s = ST_RESULT;
          end
        end
        default: s = ST_REJECT;
      endcase
      want_energy.insert(want_energy.size(), e);
      want_status.insert(want_status.size(), s);
    endfunction

    task check_result(logic [31:0] e, logic [2:0] s);
      logic [31:0] we;
      logic [2:0] ws;
      if (want_status.size() == 0) begin
        report_mismatch($sformatf("unexpected result energy=%h status=%0d", e, s));
        return;
      end
      we = want_energy.pop_front();
      ws = want_status.pop_front();
      if (s !== ws)
        report_mismatch($sformatf("status got %0d want %0d", s, ws));
      if (e !== we)
        report_mismatch($sformatf("energy got %h want %h", e, we));
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] op;
  logic [31:0] key_range, point_energy;
  logic out_valid, out_stall;
  logic [31:0] energy;
  logic [2:0] status;

  energy_scoreboard board;
  bit calm;        // last part of the run: no idling on either side
  bit hold_off;    // long receiver hold-off, driven by its own process

  piecewise_linear_table_interp #(.TABLE_DEPTH(Depth)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .key_range(key_range), .point_energy(point_energy),
    .out_valid(out_valid), .out_stall(out_stall),
    .energy(energy), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net: the slowest run is roughly 900 items, with idle gaps on each
  // side, far below this bound.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // Offers one item and holds it steady until the transfer happens. A random
  // gap of idle cycles may precede the item unless the run is calm.
  task automatic send_item(logic [1:0] o, logic [31:0] key, logic [31:0] pe);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    key_range <= key;
    point_energy <= pe;
    do @(posedge clk); while (in_stall);
    // The transfer took place at this edge; record what was sent.
    board.note_input(o, key, pe);
  endtask

  // Random table contents: ranges increase with random strides, small or huge.
  task automatic fill_table(int n, bit wide);
    logic [31:0] r;
    int i;
    r = wide ? $urandom_range(0, 15) : $urandom;
    for (i = 0; i < n; i++) begin
      send_item(OP_APPEND, r, $urandom);
      if (wide) r = r + $urandom_range(1, 32'h00ff_ffff);
      else r = r + $urandom_range(1, 300);
    end
  endtask

  // Queries mostly fall between the stored points of the table.
  task automatic query_burst(int n);
    int i;
    logic [31:0] lo_r, hi_r, k;
    for (i = 0; i < n; i++) begin
      if (board.count >= 2 && $urandom_range(0, 7) != 0) begin
        lo_r = board.ranges[0];
        hi_r = board.ranges[board.count-1];
        k = lo_r + $urandom_range(0, hi_r - lo_r);
      end else begin
        k = $urandom;
      end
      send_item(OP_QUERY, k, $urandom);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off that fills the block.
  initial begin
    int burst;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Results are checked at every edge where a transfer happens.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(energy, status);
  end

  initial begin
    int phase, i, n;
    board = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= OP_CLEAR;
    key_range <= '0;
    point_energy <= '0;
    calm = 1'b0;
    hold_off = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: queries on an empty and a one-point table, unused code,
    // equal and lower appends, edge and interior queries, decreasing energy.
    send_item(OP_QUERY, 32'h0001_0000, '0);
    send_item(OP_NONE, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_APPEND, 32'h0000_0000, 32'hffff_ffff);
    send_item(OP_QUERY, 32'h0000_0001, '0);
    send_item(OP_APPEND, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_APPEND, 32'h0010_0000, 32'h0000_0000);
    send_item(OP_APPEND, 32'h0008_0000, 32'h1234_5678);
    send_item(OP_APPEND, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_QUERY, 32'h0000_0000, '0);
    send_item(OP_QUERY, 32'hffff_ffff, '0);
    send_item(OP_QUERY, 32'h0010_0000, '0);
    send_item(OP_QUERY, 32'h0000_0001, '0);
    send_item(OP_QUERY, 32'hffff_fffe, '0);
    send_item(OP_QUERY, 32'h8000_0000, '0);
    send_item(OP_NONE, '0, '0);
    send_item(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_QUERY, 32'h8000_0000, '0);
    send_item(OP_APPEND, 32'h0000_0100, 32'hffff_ffff);
    send_item(OP_APPEND, 32'h0000_0200, 32'h0000_0000);
    send_item(OP_QUERY, 32'h0000_0180, '0);
    send_item(OP_QUERY, 32'h0000_01ff, '0);

    // Full table: 256 points, then an append that must be rejected.
    send_item(OP_CLEAR, '0, '0);
    fill_table(Depth, 1'b1);
    send_item(OP_APPEND, 32'hffff_ffff, '0);
    query_burst(20);

    // Long receiver hold-off while the sender keeps offering items.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      query_burst(6);
    join

    // Random phases: mostly a fill then queries, with some noise items.
    for (phase = 0; phase < 24; phase++) begin
      if (phase == 20) calm = 1'b1;
      send_item(OP_CLEAR, $urandom, $urandom);
      n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(2, 12);
      fill_table(n, 1'($urandom_range(0, 1)));
      for (i = 0; i < 3; i++)
        send_item(2'($urandom_range(0, 3)), $urandom, $urandom);
      query_burst(8);
    end

    in_valid <= 1'b0;
    while (board.want_status.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/pwl_pkg.sv
hw/rtl/pwl_divider.sv
hw/rtl/pwl_table_mem.sv
hw/rtl/piecewise_linear_table_interp.sv
tb/sv/piecewise_linear_table_interp_test.sv
